### src/assert_macros.svh
// Assertion helper macros for the RTL of the spline basis block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define SBF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbf assertion failed: same-cycle implication");

// Next-cycle implication, checked outside of reset.
`define SBF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbf assertion failed: next-cycle implication");

`endif

### src/sbf_pkg.sv
// Shared constants and types of the spline basis forward block.
// No dependencies; used by the controller, the datapath and the top level.
package sbf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_DIMS  = 3;
  localparam int KS_W      = 7;
  localparam int PW        = FRAC_BITS + 1;

  localparam logic [PW-1:0]   ONE      = 17'h10000;
  localparam logic [KS_W-1:0] KS_MAX   = 7'd64;
  localparam logic [21:0]     RECIP6   = 22'd2796202;
  localparam int              RECIP_SH = 24;

  // Configuration register indexes.
  localparam logic [2:0] REG_DEGREE   = 3'd0;
  localparam logic [2:0] REG_NUM_DIMS = 3'd1;
  localparam logic [2:0] REG_KS0      = 3'd2;
  localparam logic [2:0] REG_KS1      = 3'd3;
  localparam logic [2:0] REG_KS2      = 3'd4;
  localparam logic [2:0] REG_OPEN     = 3'd5;

  // Steps of the basis piece evaluation for one dimension.
  localparam logic [1:0] STEP_SQ  = 2'd0;
  localparam logic [1:0] STEP_NUM = 2'd1;
  localparam logic [1:0] STEP_REC = 2'd2;
  localparam logic [1:0] STEP_FIX = 2'd3;

  typedef struct packed {
    logic [1:0]                 deg;
    logic [1:0]                 dims;
    logic [2:0][KS_W-1:0]       ks;
    logic [2:0]                 open_m;
  } cfg_t;

  typedef struct packed {
    logic       capture;
    logic       scale;
    logic       piece;
    logic [1:0] step;
    logic [1:0] dim;
    logic       issue;
    logic [1:0] k0;
    logic [1:0] k1;
    logic [1:0] k2;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic adv;
    logic empty;
  } stat_t;

endpackage

### src/spline_basis_forward.sv
// Top level of the spline basis forward block: configuration registers,
// controller and datapath. Depends on sbf_pkg, sbf_ctrl, sbf_datapath, assert_macros.svh.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   pseudo_0..2
//   out_     output     out_valid/out_stall basis, wgt_idx, last
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One edge is first set up (capture, scaling, four piece steps for each of three
// dimensions) and then gives one result per cycle while the output does not stall,
// through a three-stage multiply pipeline, (degree+1)^num_dims results in all.
// A new edge is taken only once the last result has left the output register
// and the controller is idle again. Output stall freezes the whole result pipeline.
// Reset is synchronous and returns the registers to their defaults and the controller to idle.
module spline_basis_forward (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [16:0] in_pseudo_0,
  input  logic [16:0] in_pseudo_1,
  input  logic [16:0] in_pseudo_2,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_basis,
  output logic [17:0] out_wgt_idx,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  `include "assert_macros.svh"

  logic [1:0]     degree_r, num_dims_r;
  logic [2:0][6:0] ks_r;
  logic [2:0]     open_mask_r;
  sbf_pkg::cfg_t  cfg;
  sbf_pkg::cmd_t  cmd;
  sbf_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r    <= 2'd1;
      num_dims_r  <= 2'd1;
      ks_r        <= {3{7'd2}};
      open_mask_r <= 3'd7;
    end else if (cfg_valid) begin
      case (cfg_index)
        sbf_pkg::REG_DEGREE:   degree_r    <= cfg_data[1:0];
        sbf_pkg::REG_NUM_DIMS: num_dims_r  <= cfg_data[1:0];
        sbf_pkg::REG_KS0:      ks_r[0]     <= cfg_data;
        sbf_pkg::REG_KS1:      ks_r[1]     <= cfg_data;
        sbf_pkg::REG_KS2:      ks_r[2]     <= cfg_data;
        sbf_pkg::REG_OPEN:     open_mask_r <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.deg    = (degree_r == 2'd0) ? 2'd1 : degree_r;
    cfg.dims   = (num_dims_r == 2'd0) ? 2'd1 : num_dims_r;
    cfg.open_m = open_mask_r;
    for (int d = 0; d < sbf_pkg::MAX_DIMS; d++) begin
      if (ks_r[d] == 7'd0) begin
        cfg.ks[d] = 7'd1;
      end else if (ks_r[d] > sbf_pkg::KS_MAX) begin
        cfg.ks[d] = sbf_pkg::KS_MAX;
      end else begin
        cfg.ks[d] = ks_r[d];
      end
    end
  end

  sbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sbf_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .cmd         (cmd),
    .stat        (stat),
    .in_pseudo_0 (in_pseudo_0),
    .in_pseudo_1 (in_pseudo_1),
    .in_pseudo_2 (in_pseudo_2),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_basis   (out_basis),
    .out_wgt_idx (out_wgt_idx),
    .out_last    (out_last)
  );

  // A new request is only taken when no result of the previous one is pending.
  `SBF_ASSERT_IMP(a_accept_when_empty, clk, rst_n, in_valid && !in_stall, stat.empty)
  // After the final result leaves, nothing more is shown for that edge.
  `SBF_ASSERT_NXT(a_quiet_after_last, clk, rst_n, out_valid && !out_stall && out_last, !out_valid)

endmodule

### src/sbf_ctrl.sv
// Controller of the spline basis block: sequences scaling, piece evaluation
// and result issue. Depends on sbf_pkg.
module sbf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  sbf_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_stall,
  input  sbf_pkg::stat_t stat,
  output sbf_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCALE = 3'd1;
  localparam logic [2:0] ST_PIECE = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [1:0] step_r, step_nxt;
  logic [1:0] dim_r, dim_nxt;
  logic [1:0] k0_r, k0_nxt, k1_r, k1_nxt, k2_r, k2_nxt;
  logic [1:0] max0, max1, max2;
  logic       last;

  assign max0 = cfg.deg;
  assign max1 = (cfg.dims >= 2'd2) ? cfg.deg : 2'd0;
  assign max2 = (cfg.dims == 2'd3) ? cfg.deg : 2'd0;
  assign last = (k0_r == max0) && (k1_r == max1) && (k2_r == max2);

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    dim_nxt     = dim_r;
    k0_nxt      = k0_r;
    k1_nxt      = k1_r;
    k2_nxt      = k2_r;
    cmd         = '0;
    cmd.step    = step_r;
    cmd.dim     = dim_r;
    cmd.k0      = k0_r;
    cmd.k1      = k1_r;
    cmd.k2      = k2_r;
    cmd.last    = last;
    case (state_r)
      ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_PIECE;
        step_nxt  = sbf_pkg::STEP_SQ;
        dim_nxt   = 2'd0;
      end
      ST_PIECE: begin
        cmd.piece = 1'b1;
        step_nxt  = step_r + 2'd1;
        if (step_r == sbf_pkg::STEP_FIX) begin
          if (dim_r == 2'(sbf_pkg::MAX_DIMS - 1)) begin
            state_nxt = ST_EMIT;
            k0_nxt    = 2'd0;
            k1_nxt    = 2'd0;
            k2_nxt    = 2'd0;
          end else begin
            dim_nxt = dim_r + 2'd1;
          end
        end
      end
      ST_EMIT: begin
        if (stat.adv) begin
          cmd.issue = 1'b1;
          if (last) begin
            state_nxt = ST_DRAIN;
          end else if (k0_r != max0) begin
            k0_nxt = k0_r + 2'd1;
          end else if (k1_r != max1) begin
            k0_nxt = 2'd0;
            k1_nxt = k1_r + 2'd1;
          end else begin
            k0_nxt = 2'd0;
            k1_nxt = 2'd0;
            k2_nxt = k2_r + 2'd1;
          end
        end
      end
      ST_DRAIN: begin
        if (stat.empty) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= 2'd0;
      dim_r   <= 2'd0;
      k0_r    <= 2'd0;
      k1_r    <= 2'd0;
      k2_r    <= 2'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      dim_r   <= dim_nxt;
      k0_r    <= k0_nxt;
      k1_r    <= k1_nxt;
      k2_r    <= k2_nxt;
    end
  end

endmodule

### src/sbf_datapath.sv
// Datapath of the spline basis block: coordinate scaling, basis piece
// evaluation per dimension and the three-stage result pipeline. Depends on sbf_pkg.
module sbf_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  sbf_pkg::cfg_t  cfg,
  input  sbf_pkg::cmd_t  cmd,
  output sbf_pkg::stat_t stat,
  input  logic [16:0]    in_pseudo_0,
  input  logic [16:0]    in_pseudo_1,
  input  logic [16:0]    in_pseudo_2,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [16:0]    out_basis,
  output logic [17:0]    out_wgt_idx,
  output logic           out_last
);

  localparam int PW = sbf_pkg::PW;
  localparam int FB = sbf_pkg::FRAC_BITS;

  logic [2:0][PW-1:0]           p_r;
  logic [2:0][6:0]              int_r;
  logic [2:0][FB-1:0]           frac_r;
  logic [12:0]                  off2_r;

  logic [FB-1:0]                f_r;
  logic [PW-1:0]                g_r;
  logic [31:0]                  ff_r;
  logic [32:0]                  gg_r;
  logic [3:0][19:0]             n_r;
  logic [2:0][PW-1:0]           qd_r;
  logic [3:0][17:0]             qe_r;
  logic [2:0][3:0][PW-1:0]      pc_r;
  logic [2:0][3:0][5:0]         md_r;

  logic                         v1_r, v2_r, out_valid_r;
  logic [PW-1:0]                b1_r, b2_r, basis_r;
  logic [17:0]                  w1_r, w2_r, w_r;
  logic [1:0]                   k1_1_r, k2_1_r, k2_2_r;
  logic                         last1_r, last2_r, last_r;
  logic                         adv;

  // Intermediate values of scaling, the piece steps and the result pipeline.
  logic [FB-1:0]                f2;
  logic [PW-1:0]                g2;
  logic [PW-1:0]                g_in;
  logic [33:0]                  q1_sum;
  logic [33:0]                  m0;
  logic [31:0]                  m3;
  logic [18:0]                  c6;
  logic [34:0]                  m1;
  logic [32:0]                  m2;
  logic [35:0]                  n1_sum, n2_sum;
  logic [3:0][41:0]             rprod;
  logic [33:0]                  bm2, bm3;
  logic [3:0][PW-1:0]           cubic;
  logic [3:0][PW-1:0]           pieces;
  logic [3:0][5:0]              mods;
  logic [2:0][PW-1:0]           psat;
  logic [2:0][23:0]             prod;
  logic [2:0][6:0]              span;

  function automatic logic [5:0] mod_small(input logic [7:0] v, input logic [6:0] ks);
    logic [7:0] t;
    t = v;
    for (int i = 0; i < 4; i++) begin
      if (t >= {1'b0, ks}) begin
        t = t - {1'b0, ks};
      end
    end
    return t[5:0];
  endfunction

  assign psat[0] = (in_pseudo_0 > sbf_pkg::ONE) ? sbf_pkg::ONE : in_pseudo_0;
  assign psat[1] = (in_pseudo_1 > sbf_pkg::ONE) ? sbf_pkg::ONE : in_pseudo_1;
  assign psat[2] = (in_pseudo_2 > sbf_pkg::ONE) ? sbf_pkg::ONE : in_pseudo_2;

  always_comb begin
    for (int d = 0; d < sbf_pkg::MAX_DIMS; d++) begin
      if (cfg.open_m[d]) begin
        span[d] = (cfg.ks[d] > {5'd0, cfg.deg}) ? cfg.ks[d] - {5'd0, cfg.deg} : 7'd0;
      end else begin
        span[d] = cfg.ks[d];
      end
      prod[d] = p_r[d] * span[d];
    end
  end

  assign g_in   = sbf_pkg::ONE - {1'b0, frac_r[cmd.dim]};
  assign f2     = ff_r[31:16];
  assign g2     = gg_r[32:16];
  assign q1_sum = {2'b0, f_r, 16'b0} + 34'h0_8000_0000 - {2'b0, ff_r};
  assign m0     = g2 * g_r;
  assign m3     = f2 * f_r;
  assign c6     = 19'd393216 - 19'(3 * f_r);
  assign m1     = f2 * c6;
  assign m2     = f2 * g_r;
  assign n1_sum = 36'h4_0000_0000 - {1'b0, m1};
  assign n2_sum = 36'(3 * {3'b0, m2}) + 36'(3 * {4'b0, f_r, 16'b0}) + 36'h1_0000_0000;
  assign bm2    = b1_r * pc_r[1][k1_1_r];
  assign bm3    = b2_r * pc_r[2][k2_2_r];

  // Division by six: the reciprocal estimate is low by at most one.
  always_comb begin
    logic [20:0] rem;
    for (int i = 0; i < 4; i++) begin
      rprod[i] = n_r[i] * sbf_pkg::RECIP6;
      rem = {1'b0, n_r[i]} - 21'(6 * qe_r[i]);
      cubic[i] = (rem >= 21'd6) ? PW'(qe_r[i] + 18'd1) : qe_r[i][PW-1:0];
    end
    case (cfg.deg)
      2'd2: pieces = {{PW{1'b0}}, qd_r[2], qd_r[1], qd_r[0]};
      2'd3: pieces = cubic;
      default: pieces = {{PW{1'b0}}, {PW{1'b0}}, {1'b0, f_r}, g_r};
    endcase
    for (int k = 0; k < 4; k++) begin
      mods[k] = mod_small({1'b0, int_r[cmd.dim]} + 8'(k), cfg.ks[cmd.dim]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      p_r <= psat;
    end
    if (cmd.scale) begin
      for (int d = 0; d < sbf_pkg::MAX_DIMS; d++) begin
        int_r[d]  <= prod[d][22:16];
        frac_r[d] <= prod[d][15:0];
      end
      off2_r <= cfg.ks[0] * cfg.ks[1];
    end
    if (cmd.piece) begin
      case (cmd.step)
        sbf_pkg::STEP_SQ: begin
          f_r  <= frac_r[cmd.dim];
          g_r  <= g_in;
          ff_r <= frac_r[cmd.dim] * frac_r[cmd.dim];
          gg_r <= {16'd0, g_in} * {16'd0, g_in};
        end
        sbf_pkg::STEP_NUM: begin
          qd_r[0] <= {1'b0, gg_r[32:17]};
          qd_r[1] <= q1_sum[32:16];
          qd_r[2] <= {2'b0, ff_r[31:17]};
          n_r[0]  <= {2'b0, m0[33:16]};
          n_r[1]  <= n1_sum[35:16];
          n_r[2]  <= n2_sum[35:16];
          n_r[3]  <= {4'b0, m3[31:16]};
        end
        sbf_pkg::STEP_REC: begin
          for (int i = 0; i < 4; i++) begin
            qe_r[i] <= 18'(rprod[i] >> sbf_pkg::RECIP_SH);
          end
        end
        sbf_pkg::STEP_FIX: begin
          pc_r[cmd.dim] <= pieces;
          md_r[cmd.dim] <= mods;
        end
        default: begin
        end
      endcase
    end
  end

  // Result pipeline: all stages move together when the output can take data.
  assign adv = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= cmd.issue;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_r    <= pc_r[0][cmd.k0];
      w1_r    <= (cfg.dims >= 2'd2) ?
                 18'(md_r[0][cmd.k0]) + 18'(cfg.ks[0]) * 18'(md_r[1][cmd.k1]) :
                 18'(md_r[0][cmd.k0]);
      k1_1_r  <= cmd.k1;
      k2_1_r  <= cmd.k2;
      last1_r <= cmd.last;

      b2_r    <= (cfg.dims >= 2'd2) ? PW'(bm2 >> FB) : b1_r;
      w2_r    <= (cfg.dims == 2'd3) ? 18'(w1_r + off2_r * md_r[2][k2_1_r]) : w1_r;
      k2_2_r  <= k2_1_r;
      last2_r <= last1_r;

      basis_r <= (cfg.dims == 2'd3) ? PW'(bm3 >> FB) : b2_r;
      w_r     <= w2_r;
      last_r  <= last2_r;
    end
  end

  assign stat.adv    = adv;
  assign stat.empty  = !v1_r && !v2_r && !out_valid_r;
  assign out_valid   = out_valid_r;
  assign out_basis   = basis_r;
  assign out_wgt_idx = w_r;
  assign out_last    = last_r;

endmodule
